// File: rtl/rc5_pkg.sv
// Shared types and constants for the RC5 cipher engine.
`default_nettype none
package rc5_pkg;

  localparam int unsigned WordBitsDef    = 32;
  localparam int unsigned MaxRoundsDef   = 32;
  localparam int unsigned MaxKeyBytesDef = 16;

  localparam logic [2:0] KIND_EXPAND = 3'd0;
  localparam logic [2:0] KIND_ENC    = 3'd1;
  localparam logic [2:0] KIND_DEC    = 3'd2;
  localparam logic [2:0] KIND_PENC   = 3'd3;
  localparam logic [2:0] KIND_PDEC   = 3'd4;

  localparam logic [1:0] REG_ROUNDS  = 2'd0;
  localparam logic [1:0] REG_KEY_LEN = 2'd1;
  localparam logic [1:0] REG_KEY_LO  = 2'd2;
  localparam logic [1:0] REG_KEY_HI  = 2'd3;

  localparam logic [5:0] ROUNDS_RESET  = 6'd12;
  localparam logic [4:0] KEY_LEN_RESET = 5'd16;

  localparam logic [63:0] MAGIC_P64 = 64'hb7e151628aed2a6b;
  localparam logic [63:0] MAGIC_Q64 = 64'h9e3779b97f4a7c15;
  localparam logic [31:0] MAGIC_P32 = 32'hb7e15163;
  localparam logic [31:0] MAGIC_Q32 = 32'h9e3779b9;
  localparam logic [15:0] MAGIC_P16 = 16'hb7e1;
  localparam logic [15:0] MAGIC_Q16 = 16'h9e37;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_first;
    logic [31:0] out_second;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [63:0] data;
  } cfg_wr_t;

  // Control from the sequencer to one cell.
  typedef struct packed {
    logic load;   // take a fresh block from the sequencer
    logic step;   // run one round
    logic dec;    // decrypt direction
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/rc5_cell.sv
// One cipher cell: holds a two-word block and applies one half-round pair per step.
`default_nettype none
module rc5_cell
  import rc5_pkg::*;
#(
  parameter int unsigned WordBits = WordBitsDef
) (
  input  wire logic                clk_i,
  input  wire cell_ctl_t           ctl_i,
  input  wire logic [WordBits-1:0] load_a_i,
  input  wire logic [WordBits-1:0] load_b_i,
  input  wire logic [WordBits-1:0] key_even_i,
  input  wire logic [WordBits-1:0] key_odd_i,
  output logic      [WordBits-1:0] a_o,
  output logic      [WordBits-1:0] b_o
);
  localparam int unsigned SB = $clog2(WordBits);

  logic [WordBits-1:0] a_q, b_q, a_d, b_d, ea, eb, dbt, dat;

  function automatic logic [WordBits-1:0] rotl(input logic [WordBits-1:0] x,
                                               input logic [WordBits-1:0] y);
    logic [SB-1:0] s;
    logic [2*WordBits-1:0] w;
    s = SB'(y % WordBits);
    w = {x, x} << s;
    return w[2*WordBits-1 -: WordBits];
  endfunction

  function automatic logic [WordBits-1:0] rotr(input logic [WordBits-1:0] x,
                                               input logic [WordBits-1:0] y);
    logic [SB-1:0] s;
    logic [2*WordBits-1:0] w;
    s = SB'(y % WordBits);
    w = {x, x} >> s;
    return w[WordBits-1:0];
  endfunction

  always_comb begin
    ea  = rotl(a_q ^ b_q, b_q) + key_even_i;
    eb  = rotl(b_q ^ ea, ea) + key_odd_i;
    dbt = rotr(b_q - key_odd_i, a_q) ^ a_q;
    dat = rotr(a_q - key_even_i, dbt) ^ dbt;
    a_d = a_q;
    b_d = b_q;
    if (ctl_i.load) begin
      a_d = load_a_i;
      b_d = load_b_i;
    end else if (ctl_i.step) begin
      a_d = ctl_i.dec ? dat : ea;
      b_d = ctl_i.dec ? dbt : eb;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign a_o = a_q;
  assign b_o = b_q;
endmodule
`default_nettype wire

// File: rtl/rc5_block_cipher_with_key_schedule.sv
// RC5 engine top: config registers, key schedule, round-key memory, two cipher cells.
//
// Usage: configure rounds, key_length, key_low, key_high over the cfg port
// (cfg_valid/cfg_ready, index 0..3) while idle, then send kind 0 to expand the key.
// Input channel in_valid/in_stall carries one in_item_t per beat; output
// channel out_valid/out_stall returns out_item_t beats, last marking the
// final beat of an item. Kind 0/1/2 give one beat, kind 3 two, kind 4 one;
// kinds 5..7 are dropped without a beat.
// Timing: two cipher cells run side by side, one round per cycle, reading
// the round-key memory through one port per half-round key. CPRE fetches
// keys and loads the cells, CRUN runs the rounds (an encrypt whitens
// first), CFIN loads the result (a decrypt unwhitens) and OUT holds the
// beats. Key expansion writes 2*(r+1) table words, then runs 3*max(t,c)
// mixing steps, each a memory read then a write. One item is in flight at
// a time; in_stall stays high until the sequencer is back in idle after the
// last beat is taken. Reset: config registers take their reset values and
// the round-key table reads as zero through per-entry valid bits; scratch
// key words are reloaded from the key registers at every expansion. A
// stalled output holds its beat; a second beat of a kind 3 encrypt waits in
// its own register until the first is taken.
`default_nettype none
module rc5_block_cipher_with_key_schedule
  import rc5_pkg::*;
#(
  parameter int unsigned WordBits    = WordBitsDef,
  parameter int unsigned MaxRounds   = MaxRoundsDef,
  parameter int unsigned MaxKeyBytes = MaxKeyBytesDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data_i,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data_o,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire cfg_wr_t  cfg_data_i
);
  localparam int unsigned Depth    = 2 * (MaxRounds + 1);
  localparam int unsigned IdxW     = $clog2(Depth);
  localparam int unsigned BpW      = WordBits / 8;
  localparam int unsigned KWords   = (MaxKeyBytes + BpW - 1) / BpW;
  localparam int unsigned KwW      = (KWords > 1) ? $clog2(KWords) : 1;
  localparam int unsigned RW       = $clog2(MaxRounds + 1);
  localparam int unsigned CntW     = $clog2(3 * Depth + 1);
  localparam int unsigned SB       = $clog2(WordBits);
  localparam logic [WordBits-1:0] MagP = (WordBits <= 16) ? WordBits'(MAGIC_P16) :
                                         (WordBits <= 32) ? WordBits'(MAGIC_P32) :
                                         WordBits'(MAGIC_P64);
  localparam logic [WordBits-1:0] MagQ = (WordBits <= 16) ? WordBits'(MAGIC_Q16) :
                                         (WordBits <= 32) ? WordBits'(MAGIC_Q32) :
                                         WordBits'(MAGIC_Q64);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_MIXR  = 3'd2;
  localparam logic [2:0] ST_MIXW  = 3'd3;
  localparam logic [2:0] ST_CPRE  = 3'd4;
  localparam logic [2:0] ST_CRUN  = 3'd5;
  localparam logic [2:0] ST_CFIN  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  // config
  logic [5:0]  rounds_q;
  logic [4:0]  klen_q;
  logic [63:0] key_lo_q, key_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q <= ROUNDS_RESET;
      klen_q   <= KEY_LEN_RESET;
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_data_i.index)
        REG_ROUNDS:  rounds_q <= cfg_data_i.data[5:0];
        REG_KEY_LEN: klen_q   <= cfg_data_i.data[4:0];
        REG_KEY_LO:  key_lo_q <= cfg_data_i.data;
        REG_KEY_HI:  key_hi_q <= cfg_data_i.data;
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  logic [RW-1:0]   eff_r;
  logic [4:0]      eff_b;
  logic [IdxW:0]   t_words;
  logic [KwW:0]    c_words;
  logic [CntW-1:0] n_steps;
  always_comb begin
    if (rounds_q == 6'd0) eff_r = RW'(1);
    else if (32'(rounds_q) > MaxRounds) eff_r = RW'(MaxRounds);
    else eff_r = RW'(rounds_q);
    if (klen_q == 5'd0) eff_b = 5'd1;
    else if (32'(klen_q) > MaxKeyBytes) eff_b = 5'(MaxKeyBytes);
    else eff_b = klen_q;
    t_words = (IdxW+1)'(2 * (32'(eff_r) + 1));
    c_words = (KwW+1)'((32'(eff_b) + BpW - 1) / BpW);
    n_steps = CntW'(3 * ((32'(t_words) > 32'(c_words)) ? 32'(t_words) : 32'(c_words)));
  end

  // round-key memory with valid bits (reset reads as zero)
  logic [WordBits-1:0] tbl_mem [Depth];
  logic [Depth-1:0]    tbl_vld_q;
  logic                tbl_we;
  logic [IdxW-1:0]     tbl_waddr, rd_e_addr, rd_o_addr;
  logic [WordBits-1:0] tbl_wdata, rd_e_raw, rd_o_raw, rd_e, rd_o;
  logic                rd_e_v, rd_o_v;

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    rd_e_raw <= tbl_mem[rd_e_addr];
    rd_o_raw <= tbl_mem[rd_o_addr];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
      rd_e_v    <= 1'b0;
      rd_o_v    <= 1'b0;
    end else begin
      if (tbl_we) tbl_vld_q[tbl_waddr] <= 1'b1;
      rd_e_v <= tbl_vld_q[rd_e_addr];
      rd_o_v <= tbl_vld_q[rd_o_addr];
    end
  end
  assign rd_e = rd_e_v ? rd_e_raw : '0;
  assign rd_o = rd_o_v ? rd_o_raw : '0;

  // sequencer
  logic [2:0]          st_q, st_d;
  in_item_t            item_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [IdxW-1:0]     ii_q, ii_d;
  logic [KwW-1:0]      jj_q, jj_d;
  logic [WordBits-1:0] ma_q, ma_d, mb_q, mb_d, prev_q, prev_d;
  logic [WordBits-1:0] kw_q [KWords];
  logic [WordBits-1:0] kw_load [KWords];
  logic                kw_init, kw_we;
  logic [WordBits-1:0] kw_wdata;
  logic                dec;
  cell_ctl_t           ctl;
  logic [WordBits-1:0] c0a, c0b, c1a, c1b;
  logic [WordBits-1:0] l0a, l0b, l1a, l1b;
  logic [WordBits-1:0] mix_a, mix_b, sum_ab;

  // output registers: primary and a second queued beat
  logic      ov_q, ov2_q;
  out_item_t od_q, od2_q;

  function automatic logic [WordBits-1:0] rotl(input logic [WordBits-1:0] x,
                                               input logic [WordBits-1:0] y);
    logic [SB-1:0] s;
    logic [2*WordBits-1:0] w;
    s = SB'(y % WordBits);
    w = {x, x} << s;
    return w[2*WordBits-1 -: WordBits];
  endfunction

  always_comb begin
    for (int w = 0; w < KWords; w++) begin
      kw_load[w] = '0;
      for (int by = BpW - 1; by >= 0; by--) begin
        if (w * BpW + by < 32'(eff_b) && w * BpW + by < 16) begin
          kw_load[w] = kw_load[w] << 8;
          kw_load[w][7:0] = (w * BpW + by < 8) ? key_lo_q[((w*BpW+by)%8)*8 +: 8]
                                               : key_hi_q[((w*BpW+by)%8)*8 +: 8];
        end
      end
    end
  end

  assign dec = (item_q.kind == KIND_DEC) || (item_q.kind == KIND_PDEC);
  assign sum_ab = ma_q + mb_q;
  assign mix_a  = rotl(rd_e + sum_ab, WordBits'(3));
  assign mix_b  = rotl(kw_q[jj_q] + mix_a + mb_q, mix_a + mb_q);

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; ii_d = ii_q; jj_d = jj_q;
    ma_d = ma_q; mb_d = mb_q; prev_d = prev_q;
    tbl_we = 1'b0; tbl_waddr = ii_q; tbl_wdata = '0;
    rd_e_addr = ii_q; rd_o_addr = ii_q;
    kw_init = 1'b0; kw_we = 1'b0; kw_wdata = mix_b;
    ctl = '0; ctl.dec = dec;
    l0a = '0; l0b = '0; l1a = '0; l1b = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          unique case (in_data_i.kind)
            KIND_EXPAND: begin
              st_d = ST_INIT; ii_d = '0; prev_d = MagP; kw_init = 1'b1;
            end
            KIND_ENC, KIND_DEC, KIND_PENC, KIND_PDEC: st_d = ST_CPRE;
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        tbl_we = 1'b1; tbl_wdata = prev_q; prev_d = prev_q + MagQ;
        if (32'(ii_q) + 1 == 32'(t_words)) begin
          st_d = ST_MIXR; ii_d = '0; jj_d = '0; cnt_d = '0; ma_d = '0; mb_d = '0;
        end else ii_d = ii_q + 1'b1;
      end
      ST_MIXR: begin
        rd_e_addr = ii_q; st_d = ST_MIXW;
      end
      ST_MIXW: begin
        tbl_we = 1'b1; tbl_wdata = mix_a; kw_we = 1'b1;
        ma_d = mix_a; mb_d = mix_b;
        ii_d = (32'(ii_q) + 1 == 32'(t_words)) ? '0 : ii_q + 1'b1;
        jj_d = (32'(jj_q) + 1 == 32'(c_words)) ? '0 : jj_q + 1'b1;
        cnt_d = cnt_q + 1'b1;
        st_d = (cnt_q + 1'b1 == n_steps) ? ST_OUT : ST_MIXR;
      end
      ST_CPRE: begin
        // fetch whitening words (enc) or top round keys (dec)
        if (dec) begin
          rd_e_addr = IdxW'(2 * 32'(eff_r));
          rd_o_addr = IdxW'(2 * 32'(eff_r) + 1);
          cnt_d = CntW'(eff_r);
        end else begin
          rd_e_addr = '0; rd_o_addr = IdxW'(1); cnt_d = CntW'(1);
        end
        st_d = ST_CRUN;
        ctl.load = 1'b1;
        if (item_q.kind == KIND_PENC) begin
          l0a = item_q.word_a; l0b = item_q.word_c;
          l1a = item_q.word_b; l1b = item_q.word_d;
        end else begin
          l0a = item_q.word_a; l0b = item_q.word_b;
          l1a = item_q.word_c; l1b = item_q.word_d;
        end
      end
      ST_CRUN: begin
        // cells step, or load the whitened block, with keys read last cycle; fetch keys for next round
        if (dec) begin
          ctl.step = 1'b1;
          rd_e_addr = IdxW'(2 * (32'(cnt_q) - 1));
          rd_o_addr = IdxW'(2 * (32'(cnt_q) - 1) + 1);
          if (cnt_q == CntW'(1)) st_d = ST_CFIN;
          cnt_d = cnt_q - 1'b1;
        end else begin
          if (cnt_q == CntW'(1)) begin
            ctl.load = 1'b1;
            l0a = c0a + rd_e; l0b = c0b + rd_o;
            l1a = c1a + rd_e; l1b = c1b + rd_o;
          end else ctl.step = 1'b1;
          // last round steps now; no key is needed after it
          if (32'(cnt_q) == 32'(eff_r) + 1) st_d = ST_CFIN;
          else begin
            rd_e_addr = IdxW'(2 * 32'(cnt_q));
            rd_o_addr = IdxW'(2 * 32'(cnt_q) + 1);
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CFIN: begin
        ctl.load = 1'b1;
        if (dec) begin
          l0a = c0a - rd_e; l0b = c0b - rd_o;
          l1a = c1a - rd_e; l1b = c1b - rd_o;
        end else begin
          l0a = c0a; l0b = c0b;
          l1a = c1a; l1b = c1b;
        end
        st_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q && !ov2_q) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // encrypt runs rounds 1..r at cnt 2..r+1 after whitening load at cnt 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else st_q <= st_d;
  end
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d; ii_q <= ii_d; jj_q <= jj_d;
    ma_q <= ma_d; mb_q <= mb_d; prev_q <= prev_d;
    if (st_q == ST_IDLE && in_valid && !in_stall) item_q <= in_data_i;
    for (int w = 0; w < KWords; w++) begin
      if (kw_init) kw_q[w] <= kw_load[w];
      else if (kw_we && KwW'(w) == jj_q) kw_q[w] <= kw_wdata;
    end
  end

  rc5_cell #(.WordBits(WordBits)) u_cell0 (
    .clk_i, .ctl_i(ctl), .load_a_i(l0a), .load_b_i(l0b),
    .key_even_i(rd_e), .key_odd_i(rd_o), .a_o(c0a), .b_o(c0b));
  rc5_cell #(.WordBits(WordBits)) u_cell1 (
    .clk_i, .ctl_i(ctl), .load_a_i(l1a), .load_b_i(l1b),
    .key_even_i(rd_e), .key_odd_i(rd_o), .a_o(c1a), .b_o(c1b));

  // result beats, loaded on entry to ST_OUT
  logic enter_out;
  assign enter_out = (st_d == ST_OUT) && (st_q != ST_OUT);
  logic [WordBits-1:0] f0a, f0b, f1a, f1b;
  always_comb begin
    f0a = (st_q == ST_CFIN) ? l0a : '0;
    f0b = (st_q == ST_CFIN) ? l0b : '0;
    f1a = (st_q == ST_CFIN) ? l1a : '0;
    f1b = (st_q == ST_CFIN) ? l1b : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; ov2_q <= 1'b0;
    end else if (enter_out) begin
      ov_q  <= 1'b1;
      ov2_q <= (item_q.kind == KIND_PENC);
    end else if (ov_q && !out_stall) begin
      ov_q  <= ov2_q;
      ov2_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (enter_out) begin
      od_q.out_first  <= 32'(f0a);
      od_q.out_second <= (item_q.kind == KIND_PDEC) ? 32'(f1b) : 32'(f0b);
      od_q.last       <= (item_q.kind != KIND_PENC);
      od2_q.out_first  <= 32'(f1a);
      od2_q.out_second <= 32'(f1b);
      od2_q.last       <= 1'b1;
    end else if (ov_q && !out_stall) begin
      od_q <= od2_q;
    end
  end

  assign in_stall   = (st_q != ST_IDLE);
  assign out_valid  = ov_q;
  assign out_data_o = od_q;
endmodule
`default_nettype wire

// File: rtl/rc5_checker.sv
// Port-level checker for the RC5 engine, bound to the top level.
`default_nettype none
module rc5_checker
  import rc5_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data_o))
    else $error("stalled beat changed");
  a_busy_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall)
    else $error("input open while beat pending");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall |=> !out_valid)
    else $error("beat without work");
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("beat during reset");
endmodule

bind rc5_block_cipher_with_key_schedule rc5_checker u_rc5_checker (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall, .out_data_o);
`default_nettype wire

// File: tb/rc5_block_cipher_with_key_schedule_tb.sv
// Self-checking testbench for the RC5 cipher engine with key schedule.
`timescale 1ns / 100ps
module rc5_block_cipher_with_key_schedule_tb;
  import rc5_pkg::*;

  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
  localparam int TableWords = 66;
  localparam int DrainCycles = 600;  // covers the longest key expansion, at 32 rounds

  class rc5_scoreboard;
    logic [31:0] sched[TableWords];
    logic [31:0] key_words[4];
    logic [5:0]  rounds;
    logic [4:0]  key_len;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    out_item_t   expected_beats[$];
    int          mismatches;

    function new();
      foreach (sched[i]) sched[i] = '0;
      foreach (key_words[i]) key_words[i] = '0;
      rounds = ROUNDS_RESET;
      key_len = KEY_LEN_RESET;
      key_lo = '0;
      key_hi = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        REG_ROUNDS:  rounds = val[5:0];
        REG_KEY_LEN: key_len = val[4:0];
        REG_KEY_LO:  key_lo = val;
        REG_KEY_HI:  key_hi = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] rol(logic [31:0] x, logic [31:0] s);
      return (x << s[4:0]) | (x >> (6'd32 - s[4:0]));
    endfunction

    function logic [31:0] ror(logic [31:0] x, logic [31:0] s);
      return (x >> s[4:0]) | (x << (6'd32 - s[4:0]));
    endfunction

    function int num_rounds();
      if (rounds < 1) return 1;
      if (rounds > 32) return 32;
      return rounds;
    endfunction

    function void expand_key();
      int b, t, c, n, i, j;
      logic [7:0] kb;
      logic [31:0] a, bb;
      b = (key_len < 1) ? 1 : (key_len > 16) ? 16 : key_len;
      t = 2 * (num_rounds() + 1);
      c = (b + 3) / 4;
      foreach (key_words[k]) key_words[k] = '0;
      for (int idx = b; idx > 0; idx--) begin
        kb = (idx - 1 < 8) ? key_lo[(idx - 1) * 8 +: 8] : key_hi[(idx - 9) * 8 +: 8];
        key_words[(idx - 1) / 4] = (key_words[(idx - 1) / 4] << 8) + kb;
      end
      sched[0] = MAGIC_P32;
      for (int k = 1; k < t; k++) sched[k] = sched[k - 1] + MAGIC_Q32;
      n = 3 * ((t > c) ? t : c);
      a = '0;
      bb = '0;
      i = 0;
      j = 0;
      for (int k = 0; k < n; k++) begin
        sched[i] = rol(sched[i] + a + bb, 3);
        a = sched[i];
        key_words[j] = rol(key_words[j] + a + bb, a + bb);
        bb = key_words[j];
        i = (i + 1) % t;
        j = (j + 1) % c;
      end
    endfunction

    function void encipher(logic [31:0] x, logic [31:0] y,
                           output logic [31:0] ra, output logic [31:0] rb);
      logic [31:0] a, b;
      a = x + sched[0];
      b = y + sched[1];
      for (int i = 1; i <= num_rounds(); i++) begin
        a = rol(a ^ b, b) + sched[2 * i];
        b = rol(b ^ a, a) + sched[2 * i + 1];
      end
      ra = a;
      rb = b;
    endfunction

    function void decipher(logic [31:0] x, logic [31:0] y,
                           output logic [31:0] ra, output logic [31:0] rb);
      logic [31:0] a, b;
      a = x;
      b = y;
      for (int i = num_rounds(); i > 0; i--) begin
        b = ror(b - sched[2 * i + 1], a) ^ a;
        a = ror(a - sched[2 * i], b) ^ b;
      end
      ra = a - sched[0];
      rb = b - sched[1];
    endfunction

    function void push_beat(logic [31:0] f, logic [31:0] s, logic l);
      out_item_t o;
      o.out_first = f;
      o.out_second = s;
      o.last = l;
      expected_beats.push_back(o);
    endfunction

    function void note_input(in_item_t it);
      logic [31:0] p, q, s, t;
      case (it.kind)
        KIND_EXPAND: begin
          expand_key();
          push_beat('0, '0, 1'b1);
        end
        KIND_ENC: begin
          encipher(it.word_a, it.word_b, p, q);
          push_beat(p, q, 1'b1);
        end
        KIND_DEC: begin
          decipher(it.word_a, it.word_b, p, q);
          push_beat(p, q, 1'b1);
        end
        KIND_PENC: begin
          encipher(it.word_a, it.word_c, p, q);
          encipher(it.word_b, it.word_d, s, t);
          push_beat(p, q, 1'b0);
          push_beat(s, t, 1'b1);
        end
        KIND_PDEC: begin
          decipher(it.word_a, it.word_b, p, q);
          decipher(it.word_c, it.word_d, s, t);
          push_beat(p, t, 1'b1);
        end
        default: ;  // spare codes are dropped
      endcase
    endfunction

    function void check_beat(out_item_t got);
      out_item_t exp;
      if (expected_beats.size() == 0) begin
        $error("unexpected beat %h", got);
        mismatches++;
        return;
      end
      exp = expected_beats.pop_front();
      if (got.out_first !== exp.out_first) begin
        $error("out_first exp %h got %h", exp.out_first, got.out_first);
        mismatches++;
      end
      if (got.out_second !== exp.out_second) begin
        $error("out_second exp %h got %h", exp.out_second, got.out_second);
        mismatches++;
      end
      if (got.last !== exp.last) begin
        $error("last exp %b got %b", exp.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data_i;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data_o;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_wr_t   cfg_data_i;

  rc5_scoreboard sb;
  bit busy_mode;  // when clear, neither side idles

  rc5_block_cipher_with_key_schedule dut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
    .out_valid, .out_stall, .out_data_o, .cfg_valid, .cfg_ready, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    if (!busy_mode) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= busy_mode && ($urandom_range(0, 9) < 3 ||
                                 (out_stall && $urandom_range(0, 9) < 8));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_beat(out_data_o);
  end

  task automatic send_item(logic [2:0] kind, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d);
    int g;
    in_item_t it;
    g = pick_gap();
    it.kind = kind;
    it.word_a = a;
    it.word_b = b;
    it.word_c = c;
    it.word_d = d;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic send_random(logic [2:0] kind);
    send_item(kind, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_data_i <= '{index: idx, data: val};
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [5:0] r, logic [4:0] kl, logic [63:0] lo, logic [63:0] hi);
    wait_idle();
    write_reg(REG_ROUNDS, r);
    write_reg(REG_KEY_LEN, kl);
    write_reg(REG_KEY_LO, lo);
    write_reg(REG_KEY_HI, hi);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_kind_item();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) send_random(KIND_EXPAND);
    else if (p < 10) send_random(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)));
    else send_random(3'($urandom_range(KIND_ENC, KIND_PDEC)));
  endtask

  initial begin
    logic [5:0] r;
    sb = new();
    busy_mode = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data_i = '0;
    cfg_valid = 1'b0;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, then default key, extremes of words and spare codes
    send_item(KIND_ENC, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(KIND_EXPAND, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(KIND_ENC, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(KIND_ENC, '1, '1, '1, '1);
    send_item(KIND_DEC, '1, 32'h0, '1, 32'h0);
    send_item(KIND_PENC, 32'h0, '1, '1, 32'h0);
    send_item(KIND_PDEC, '1, '1, 32'h0, 32'h0);
    send_item(KIND_SPARE_FIRST, '1, '1, '1, '1);
    send_item(KIND_SPARE_MID, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(KIND_SPARE_LAST, '1, '1, '1, '1);
    configure(6'd1, 5'd1, '1, '1);
    send_random(KIND_EXPAND);
    send_random(KIND_PENC);
    send_random(KIND_PDEC);
    configure(6'd32, 5'd16, '1, '1);
    send_random(KIND_EXPAND);
    send_random(KIND_ENC);
    configure(6'd0, 5'd0, $urandom, $urandom);
    send_random(KIND_EXPAND);
    send_random(KIND_DEC);
    configure(6'd63, 5'd31, {$urandom, $urandom}, {$urandom, $urandom});
    send_random(KIND_EXPAND);
    send_random(KIND_PENC);
    // rounds changed without a new expansion
    configure(6'd5, 5'd17, 64'h0, 64'h0);
    send_random(KIND_ENC);
    send_random(KIND_PDEC);

    busy_mode = 1'b1;
    for (int ph = 0; ph < 10; ph++) begin
      r = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 16));
      configure(r, 5'($urandom_range(0, 31)), {$urandom, $urandom}, {$urandom, $urandom});
      if ($urandom_range(0, 4) != 0) send_random(KIND_EXPAND);
      for (int n = 0; n < 58; n++) begin
        if (n % 20 == 0) busy_mode = $urandom_range(0, 3) != 0;
        random_kind_item();
      end
      busy_mode = 1'b1;
    end

    wait_idle();
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
rtl/rc5_pkg.sv
rtl/rc5_cell.sv
rtl/rc5_block_cipher_with_key_schedule.sv
rtl/rc5_checker.sv
tb/rc5_block_cipher_with_key_schedule_tb.sv
